[design/assert_macros.svh]
// assertion helper macros for the projectile step block
// no dependencies; taken in by the top level with an include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pdg_pkg.sv]
// shared constants, register codes and fixed-point helpers for the projectile step
// no dependencies
`timescale 1ns / 1ps

package pdg_pkg;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STEPS  = 56;
   localparam int SQRT_STEPS = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AIR_DENSITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CROSS_SECT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DRAG_COEF    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BULLET_MASS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIFETIME     = 3'd5;

   // item kinds
   localparam logic [1:0] KIND_LAUNCH = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_HIT    = 2'd2;

   // register reset values
   localparam logic [15:0] RHO_RESET  = 16'd5018;
   localparam logic [23:0] AREA_RESET = 24'd0;
   localparam logic [15:0] CD_RESET   = 16'd0;
   localparam logic [23:0] MASS_RESET = 24'd1;
   localparam logic [15:0] GRAV_RESET = 16'd2509;
   localparam logic [23:0] LIFE_RESET = 24'd655360;

   localparam logic [7:0]  MASS_SCALE   = 8'd200;
   localparam logic [6:0]  GRAV_SCALE   = 7'd100;
   localparam logic [63:0] SLOW_LIMIT   = 64'd6;
   localparam logic [40:0] DRAG_CAP     = 41'h100_0000_0000;
   localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : v;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
      logic signed [39:0] r;
      if (v[40] != v[39]) begin
         r = v[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
      end else begin
         r = v[39:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [31:0] r;
      if ((&v[43:31]) || !(|v[43:31])) begin
         r = v[31:0];
      end else begin
         r = v[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // pos + round(v*dt / 2^16), saturated; prod holds |v|*dt
   function automatic logic signed [39:0] seg_end(input logic signed [39:0] pos,
                                                  input logic neg,
                                                  input logic [47:0] prod);
      logic signed [49:0] sp;
      logic signed [49:0] r;
      logic signed [33:0] st;
      logic signed [40:0] sum;
      sp  = neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
      r   = sp + 50'sd32768;
      st  = r[49:16];
      sum = {{7{st[33]}}, st} + {pos[39], pos};
      return sat40(sum);
   endfunction

   // launch velocity component: round(dir*speed / 2^6), saturated
   function automatic logic signed [31:0] launch_vel(input logic neg,
                                                     input logic [39:0] prod);
      logic signed [41:0] p;
      logic signed [41:0] r;
      p = neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
      r = p + 42'sd32;
      return sat32({{8{r[41]}}, r[41:6]});
   endfunction

   // velocity component moved toward zero by d
   function automatic logic signed [43:0] drag_v(input logic signed [31:0] v,
                                                 input logic [40:0] d);
      logic signed [43:0] ve;
      logic signed [43:0] de;
      ve = {{12{v[31]}}, v};
      de = $signed({3'b000, d});
      return v[31] ? ve + de : ve - de;
   endfunction

endpackage

[design/projectile_drag_gravity_step.sv]
// projectile step: euler update of a point-mass bullet with quadratic drag and gravity
// depends on pdg_pkg and assert_macros.svh
//
//   channel | direction | handshake        | word
//   req     | in        | req_valid/stall  | kind, dt, dir xyz, speed, launch xyz
//   rsp     | out       | rsp_valid/stall  | segment start/end xyz, expired
//   csr     | in        | csr_wen          | index, data (24 bit)
//
// hit, ignored or inactive-tick word: handled in the idle state. launch: three products on the
//   shared multiplier. expiring tick: age check, then straight to the output register.
// tick: the 56-step restoring divider for the drag factor
//   (the 32-step square root runs beside it) and 22 products on the shared multiplier.
// one word at a time; req_stall is high from accepting a launch or active tick until
// idle again; a tick's result is held in the output register while rsp_stall is high.
// reset is synchronous: registers to defaults, bullet state cleared, inactive.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module projectile_drag_gravity_step import pdg_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // input words
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [15:0]                  req_dt,
   input  logic signed [15:0]           req_dir_x,
   input  logic signed [15:0]           req_dir_y,
   input  logic signed [15:0]           req_dir_z,
   input  logic [23:0]                  req_launch_speed,
   input  logic signed [39:0]           req_launch_x,
   input  logic signed [39:0]           req_launch_y,
   input  logic signed [39:0]           req_launch_z,
   // result words
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [39:0]           rsp_seg_start_x,
   output logic signed [39:0]           rsp_seg_start_y,
   output logic signed [39:0]           rsp_seg_start_z,
   output logic signed [39:0]           rsp_seg_end_x,
   output logic signed [39:0]           rsp_seg_end_y,
   output logic signed [39:0]           rsp_seg_end_z,
   output logic                         rsp_expired,
   // register writes
   input  logic                         csr_wen,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE, ST_L_X, ST_L_Y, ST_L_Z, ST_L_END,
      ST_T_AGE, ST_T_VY, ST_T_VZ, ST_T_SQX, ST_T_SQY, ST_T_SQZ, ST_T_RA,
      ST_T_KLO, ST_T_KHI, ST_T_DEN, ST_T_GH, ST_T_GV, ST_T_GSAVE, ST_T_ITER,
      ST_T_T0, ST_T_T1, ST_T_TS, ST_T_G0, ST_T_G1, ST_T_GS,
      ST_T_DX0, ST_T_DX1, ST_T_DY0, ST_T_DY1, ST_T_DZ0, ST_T_DZ1, ST_T_VEND,
      ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] rho_ff, cd_ff, grav_ff;
   logic [23:0] area_ff, mass_ff, life_ff;

   // bullet state
   logic signed [39:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [31:0] vel_x_ff, vel_y_ff, vel_z_ff;
   logic [23:0]        age_ff;
   logic               active_ff;

   // latched word
   logic [15:0]        dt_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [23:0]        speed_ff;

   // working registers
   logic [63:0]        prod_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        sq_ff;
   logic               drag_on_ff;
   logic [7:0]         rahi_ff;
   logic [55:0]        num_ff;     // numerator, shifts out into quotient
   logic [31:0]        rem_ff;
   logic [31:0]        den_ff;
   logic [63:0]        sx_ff, sres_ff, sbit_ff;
   logic [5:0]         it_ff;
   logic [63:0]        t_ff;
   logic [63:0]        g_ff;
   logic [23:0]        grav_step_ff;
   logic               exp_ff;
   logic signed [39:0] end_x_ff, end_y_ff, end_z_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [39:0] rsp_sx_ff, rsp_sy_ff, rsp_sz_ff;
   logic signed [39:0] rsp_ex_ff, rsp_ey_ff, rsp_ez_ff;
   logic               rsp_exp_ff;

   // shared multiplier operands
   logic [31:0] mul_a, mul_b;

   logic [31:0] mag_vx, mag_vy, mag_vz;
   logic [23:0] mass_eff;
   logic [24:0] age_sum;
   logic [23:0] age_sat;
   logic [32:0] div_rem2;
   logic        div_ge;
   logic [63:0] sq_trial;
   logic        sq_ge;
   logic [95:0] wide_sum;
   logic [64:0] d_raw;
   logic [40:0] d_cap;
   logic [39:0] grav_round;
   logic [55:0] k_sum;
   logic        req_accept;
   logic        out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign mag_vx   = mag32(vel_x_ff);
   assign mag_vy   = mag32(vel_y_ff);
   assign mag_vz   = mag32(vel_z_ff);
   assign mass_eff = (mass_ff == '0) ? 24'd1 : mass_ff;

   // age saturates at its width
   assign age_sum = {1'b0, age_ff} + {9'b0, dt_ff};
   assign age_sat = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];

   // one restoring divide step
   assign div_rem2 = {rem_ff, num_ff[55]};
   assign div_ge   = (div_rem2 >= {1'b0, den_ff});

   // one square root step
   assign sq_trial = sres_ff + sbit_ff;
   assign sq_ge    = (sx_ff >= sq_trial);

   // high partial product joined to the low one held in acc
   assign wide_sum = {32'b0, acc_ff} + {prod_ff, 32'b0};

   // per-component drag amount, capped, zero when the speed is at or below the slow limit
   assign d_raw = {33'b0, acc_ff[63:32]} + {1'b0, prod_ff};
   assign d_cap = !drag_on_ff ? '0 : ((d_raw > {24'b0, DRAG_CAP}) ? DRAG_CAP : d_raw[40:0]);

   assign grav_round = prod_ff[39:0] + 40'd32768;
   assign k_sum      = acc_ff[55:0] + {prod_ff[23:0], 32'b0};

   // multiplier operand select, product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_L_X:    begin mul_a = {16'b0, mag16(dir_x_ff)}; mul_b = {8'b0, speed_ff}; end
         ST_L_Y:    begin mul_a = {16'b0, mag16(dir_y_ff)}; mul_b = {8'b0, speed_ff}; end
         ST_L_Z:    begin mul_a = {16'b0, mag16(dir_z_ff)}; mul_b = {8'b0, speed_ff}; end
         ST_T_AGE:  begin mul_a = mag_vx; mul_b = {16'b0, dt_ff}; end
         ST_T_VY:   begin mul_a = mag_vy; mul_b = {16'b0, dt_ff}; end
         ST_T_VZ:   begin mul_a = mag_vz; mul_b = {16'b0, dt_ff}; end
         ST_T_SQX:  begin mul_a = mag_vx; mul_b = mag_vx; end
         ST_T_SQY:  begin mul_a = mag_vy; mul_b = mag_vy; end
         ST_T_SQZ:  begin mul_a = mag_vz; mul_b = mag_vz; end
         ST_T_RA:   begin mul_a = {16'b0, rho_ff}; mul_b = {8'b0, area_ff}; end
         ST_T_KLO:  begin mul_a = prod_ff[31:0]; mul_b = {16'b0, cd_ff}; end
         ST_T_KHI:  begin mul_a = {24'b0, rahi_ff}; mul_b = {16'b0, cd_ff}; end
         ST_T_DEN:  begin mul_a = {8'b0, mass_eff}; mul_b = {24'b0, MASS_SCALE}; end
         ST_T_GH:   begin mul_a = {16'b0, grav_ff}; mul_b = {25'b0, GRAV_SCALE}; end
         ST_T_GV:   begin mul_a = prod_ff[31:0]; mul_b = {16'b0, dt_ff}; end
         ST_T_T0:   begin mul_a = num_ff[31:0]; mul_b = sres_ff[31:0]; end
         ST_T_T1:   begin mul_a = {8'b0, num_ff[55:32]}; mul_b = sres_ff[31:0]; end
         ST_T_G0:   begin mul_a = t_ff[31:0]; mul_b = {16'b0, dt_ff}; end
         ST_T_G1:   begin mul_a = t_ff[63:32]; mul_b = {16'b0, dt_ff}; end
         ST_T_DX0:  begin mul_a = g_ff[31:0]; mul_b = mag_vx; end
         ST_T_DX1:  begin mul_a = g_ff[63:32]; mul_b = mag_vx; end
         ST_T_DY0:  begin mul_a = g_ff[31:0]; mul_b = mag_vy; end
         ST_T_DY1:  begin mul_a = g_ff[63:32]; mul_b = mag_vy; end
         ST_T_DZ0:  begin mul_a = g_ff[31:0]; mul_b = mag_vz; end
         ST_T_DZ1:  begin mul_a = g_ff[63:32]; mul_b = mag_vz; end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff  <= RHO_RESET;
         area_ff <= AREA_RESET;
         cd_ff   <= CD_RESET;
         mass_ff <= MASS_RESET;
         grav_ff <= GRAV_RESET;
         life_ff <= LIFE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_AIR_DENSITY: rho_ff  <= csr_wdata[15:0];
            REG_CROSS_SECT:  area_ff <= csr_wdata[23:0];
            REG_DRAG_COEF:   cd_ff   <= csr_wdata[15:0];
            REG_BULLET_MASS: mass_ff <= csr_wdata[23:0];
            REG_GRAVITY:     grav_ff <= csr_wdata[15:0];
            REG_LIFETIME:    life_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         vel_z_ff     <= '0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT the output register reloads below
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  case (req_kind)
                     KIND_LAUNCH: begin
                        dir_x_ff  <= req_dir_x;
                        dir_y_ff  <= req_dir_y;
                        dir_z_ff  <= req_dir_z;
                        speed_ff  <= req_launch_speed;
                        pos_x_ff  <= req_launch_x;
                        pos_y_ff  <= req_launch_y;
                        pos_z_ff  <= req_launch_z;
                        age_ff    <= '0;
                        active_ff <= 1'b1;
                        state_ff  <= ST_L_X;
                     end
                     KIND_TICK: begin
                        // an inactive bullet ignores the tick
                        if (active_ff) begin
                           dt_ff    <= req_dt;
                           state_ff <= ST_T_AGE;
                        end
                     end
                     KIND_HIT: active_ff <= 1'b0;
                     default: ;
                  endcase
               end
            end
            // launch: three products dir*speed
            ST_L_X: state_ff <= ST_L_Y;
            ST_L_Y: begin
               vel_x_ff <= launch_vel(dir_x_ff[15], prod_ff[39:0]);
               state_ff <= ST_L_Z;
            end
            ST_L_Z: begin
               vel_y_ff <= launch_vel(dir_y_ff[15], prod_ff[39:0]);
               state_ff <= ST_L_END;
            end
            ST_L_END: begin
               vel_z_ff <= launch_vel(dir_z_ff[15], prod_ff[39:0]);
               state_ff <= ST_IDLE;
            end
            // tick: age check, then segment ends
            ST_T_AGE: begin
               if (age_sat >= life_ff) begin
                  active_ff <= 1'b0;
                  exp_ff    <= 1'b1;
                  state_ff  <= ST_OUT;
               end else begin
                  age_ff   <= age_sat;
                  exp_ff   <= 1'b0;
                  state_ff <= ST_T_VY;
               end
            end
            ST_T_VY: begin
               end_x_ff <= seg_end(pos_x_ff, vel_x_ff[31], prod_ff[47:0]);
               state_ff <= ST_T_VZ;
            end
            ST_T_VZ: begin
               end_y_ff <= seg_end(pos_y_ff, vel_y_ff[31], prod_ff[47:0]);
               state_ff <= ST_T_SQX;
            end
            ST_T_SQX: begin
               end_z_ff <= seg_end(pos_z_ff, vel_z_ff[31], prod_ff[47:0]);
               state_ff <= ST_T_SQY;
            end
            // sum of squares
            ST_T_SQY: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_SQZ;
            end
            ST_T_SQZ: begin
               acc_ff   <= acc_ff + prod_ff;
               state_ff <= ST_T_RA;
            end
            ST_T_RA: begin
               sq_ff      <= acc_ff + prod_ff;
               drag_on_ff <= (acc_ff + prod_ff) > SLOW_LIMIT;
               state_ff   <= ST_T_KLO;
            end
            // rho*area*cd in two partial products
            ST_T_KLO: begin
               rahi_ff  <= prod_ff[39:32];
               state_ff <= ST_T_KHI;
            end
            ST_T_KHI: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_DEN;
            end
            ST_T_DEN: begin
               num_ff   <= k_sum;
               state_ff <= ST_T_GH;
            end
            ST_T_GH: begin
               den_ff   <= prod_ff[31:0];
               state_ff <= ST_T_GV;
            end
            ST_T_GV: state_ff <= ST_T_GSAVE;
            ST_T_GSAVE: begin
               grav_step_ff <= grav_round[39:16];
               rem_ff       <= '0;
               it_ff        <= '0;
               sx_ff        <= sq_ff;
               sres_ff      <= '0;
               sbit_ff      <= SQRT_TOP_BIT;
               state_ff     <= ST_T_ITER;
            end
            // divider and square root side by side
            ST_T_ITER: begin
               rem_ff <= div_ge ? 32'(div_rem2 - {1'b0, den_ff}) : div_rem2[31:0];
               num_ff <= {num_ff[54:0], div_ge};
               if (it_ff < 6'(SQRT_STEPS)) begin
                  if (sq_ge) begin
                     sx_ff   <= sx_ff - sq_trial;
                     sres_ff <= (sres_ff >> 1) + sbit_ff;
                  end else begin
                     sres_ff <= sres_ff >> 1;
                  end
                  sbit_ff <= sbit_ff >> 2;
               end
               it_ff <= it_ff + 6'd1;
               if (it_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= ST_T_T0;
               end
            end
            // t = c*s / 2^8, saturated
            ST_T_T0: state_ff <= ST_T_T1;
            ST_T_T1: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_TS;
            end
            ST_T_TS: begin
               t_ff     <= (|wide_sum[95:72]) ? '1 : wide_sum[71:8];
               state_ff <= ST_T_G0;
            end
            // g = t*dt / 2^18, below 2^62 so never saturates
            ST_T_G0: state_ff <= ST_T_G1;
            ST_T_G1: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_GS;
            end
            ST_T_GS: begin
               g_ff     <= {2'b00, wide_sum[79:18]};
               state_ff <= ST_T_DX0;
            end
            // per-component drag, g*|v| / 2^32
            ST_T_DX0: state_ff <= ST_T_DX1;
            ST_T_DX1: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_DY0;
            end
            ST_T_DY0: begin
               vel_x_ff <= sat32(drag_v(vel_x_ff, d_cap));
               state_ff <= ST_T_DY1;
            end
            ST_T_DY1: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_DZ0;
            end
            ST_T_DZ0: begin
               vel_y_ff <= sat32(drag_v(vel_y_ff, d_cap));
               state_ff <= ST_T_DZ1;
            end
            ST_T_DZ1: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_VEND;
            end
            ST_T_VEND: begin
               vel_z_ff <= sat32(drag_v(vel_z_ff, d_cap) - {20'b0, grav_step_ff});
               state_ff <= ST_OUT;
            end
            // hand the word to the output register
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_exp_ff   <= exp_ff;
                  if (exp_ff) begin
                     rsp_sx_ff <= '0;
                     rsp_sy_ff <= '0;
                     rsp_sz_ff <= '0;
                     rsp_ex_ff <= '0;
                     rsp_ey_ff <= '0;
                     rsp_ez_ff <= '0;
                  end else begin
                     rsp_sx_ff <= pos_x_ff;
                     rsp_sy_ff <= pos_y_ff;
                     rsp_sz_ff <= pos_z_ff;
                     rsp_ex_ff <= end_x_ff;
                     rsp_ey_ff <= end_y_ff;
                     rsp_ez_ff <= end_z_ff;
                     pos_x_ff  <= end_x_ff;
                     pos_y_ff  <= end_y_ff;
                     pos_z_ff  <= end_z_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seg_start_x = rsp_sx_ff;
   assign rsp_seg_start_y = rsp_sy_ff;
   assign rsp_seg_start_z = rsp_sz_ff;
   assign rsp_seg_end_x   = rsp_ex_ff;
   assign rsp_seg_end_y   = rsp_ey_ff;
   assign rsp_seg_end_z   = rsp_ez_ff;
   assign rsp_expired     = rsp_exp_ff;

   // checks
   `CHK_NEXT(a_hit_clears, clock, reset, req_accept && req_kind == KIND_HIT, !active_ff, "hit left bullet active")
   `CHK_SAME(a_expired_zero, clock, reset, rsp_valid_ff && rsp_exp_ff, rsp_sx_ff == 40'sd0 && rsp_ez_ff == 40'sd0, "expired word with segment data")
   `CHK_NEXT(a_out_loads, clock, reset, state_ff == ST_OUT && out_free, rsp_valid_ff && state_ff == ST_IDLE, "result not loaded")

endmodule
